// ===== rtl/core/dsf_pkg.sv =====
// Shared types, character codes and constant tables for the decimal string to fixed-point block.
// Depends on nothing; every other file of the block but dsf_if imports it.
package dsf_pkg;

   localparam int DSF_FRAC_BITS = 16;
   localparam int DSF_FRAC_DIGITS = 6;
   localparam logic [5:0] MAX_INT_CHARS_RESET = 6'd18;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MAX_INT_CHARS = 1'b0;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_LONG = 2'd1,
      ST_HEAD = 2'd2,
      ST_JUNK = 2'd3
   } dsf_status_type;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_SIGNED = 3'd1,
      PH_INT    = 3'd2,
      PH_FRAC   = 3'd3,
      PH_DONE   = 3'd4,
      PH_FAILED = 3'd5,
      PH_ENDED  = 3'd6
   } dsf_phase_type;

   typedef struct packed {
      logic           negative;
      logic           saturated;
      dsf_status_type status;
   } dsf_ctl_type;

   function automatic logic [31:0] pow10(input logic [2:0] n);
      logic [31:0] p;
      case (n)
         3'd0: p = 32'd1;
         3'd1: p = 32'd10;
         3'd2: p = 32'd100;
         3'd3: p = 32'd1000;
         3'd4: p = 32'd10000;
         3'd5: p = 32'd100000;
         3'd6: p = 32'd1000000;
         default: p = 32'd10000000;
      endcase
      return p;
   endfunction

   // bits of a fraction padded to the full digit count
   function automatic int frac_width(input int digits);
      return $clog2(pow10(3'(digits)));
   endfunction

endpackage

// ===== rtl/core/dsf_if.sv =====
// Valid/ready channel interfaces: character transactions in, parsed results out.
// Depends on nothing.
interface dsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source(output valid, output char_code, output last_char, input ready);
   modport sink(input valid, input char_code, input last_char, output ready);
endinterface

interface dsf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic [1:0]         status;

   modport source(output valid, output value, output status, input ready);
   modport sink(input valid, input value, input status, output ready);
endinterface

// ===== rtl/core/decimal_string_to_fixed.sv =====
// Top level of the ASCII decimal string to signed fixed-point converter.
// Depends on dsf_pkg, dsf_if, dsf_csr, dsf_parser and dsf_convert.
//
// req_chan takes one character (char_code, last_char) per cycle while ready.
// On the transaction with last_char set, one result transaction leaves on
// rsp_chan: value is signed fixed point with FRAC_BITS fraction bits, status
// is ok, integer part too long, bad head or trailing junk; value is zero on
// any error and saturates on integer overflow.
// Throughput is one character per cycle while req_ready is high; each
// character is one shift-add and compare step on the parse state. The
// result passes through the parse record register, the reciprocal multiply
// stage and the correction multiply stage, then the output register.
// A stalled rsp_chan fills these stages; req_ready drops only once the parse
// record register holds a result that cannot advance.
// The csr port holds max_int_chars at byte address 0, reset to 18.
// Reset clears the parse state and all pipeline valid flags.
module decimal_string_to_fixed #(
   parameter int FRAC_BITS = dsf_pkg::DSF_FRAC_BITS,
   parameter int FRAC_DIGITS = dsf_pkg::DSF_FRAC_DIGITS
) (
   input  logic                           clock,
   input  logic                           reset,
   dsf_req_if.sink                        req_chan,
   dsf_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dsf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dsf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dsf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import dsf_pkg::*;

   localparam int DW = frac_width(FRAC_DIGITS);

   logic [5:0]          max_int_chars;
   logic                fin_valid;
   logic                fin_ready;
   dsf_ctl_type         fin_ctl;
   logic [62-FRAC_BITS:0] fin_int;
   logic [DW-1:0]       fin_frac;
   logic                req_ready;
   logic                rsp_valid;
   logic signed [63:0]  rsp_value;
   logic [1:0]          rsp_status;

   dsf_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .max_int_chars (max_int_chars)
   );

   dsf_parser #(
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_ready),
      .char_code     (req_chan.char_code),
      .last_char     (req_chan.last_char),
      .max_int_chars (max_int_chars),
      .fin_valid     (fin_valid),
      .fin_ready     (fin_ready),
      .fin_ctl       (fin_ctl),
      .fin_int       (fin_int),
      .fin_frac      (fin_frac)
   );

   dsf_convert #(
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_convert (
      .clock      (clock),
      .reset      (reset),
      .fin_valid  (fin_valid),
      .fin_ready  (fin_ready),
      .fin_ctl    (fin_ctl),
      .fin_int    (fin_int),
      .fin_frac   (fin_frac),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.value = rsp_value;
   assign rsp_chan.status = rsp_status;

endmodule

// ===== rtl/core/dsf_csr.sv =====
// APB-style register port holding the integer-part length limit.
// Depends on dsf_pkg.
module dsf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dsf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dsf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dsf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [5:0]                     max_int_chars
);
   import dsf_pkg::*;

   logic [5:0] max_int_chars_ff;
   logic [5:0] max_int_chars_in;
   logic       hit;

   assign hit = csr_paddr[2] == REG_MAX_INT_CHARS;

   always_comb begin
      max_int_chars_in = max_int_chars_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         max_int_chars_in = csr_pwdata[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_int_chars_ff <= MAX_INT_CHARS_RESET;
      end else begin
         max_int_chars_ff <= max_int_chars_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? {{(CSR_DATA_W-6){1'b0}}, max_int_chars_ff} : '0;
   assign max_int_chars = max_int_chars_ff;

endmodule

// ===== rtl/core/dsf_parser.sv =====
// Per-character parse state machine with accumulators and the parse record register.
// Depends on dsf_pkg.
module dsf_parser #(
   parameter int FRAC_BITS = dsf_pkg::DSF_FRAC_BITS,
   parameter int FRAC_DIGITS = dsf_pkg::DSF_FRAC_DIGITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic [7:0]                                    char_code,
   input  logic                                          last_char,
   input  logic [5:0]                                    max_int_chars,
   output logic                                          fin_valid,
   input  logic                                          fin_ready,
   output dsf_pkg::dsf_ctl_type                          fin_ctl,
   output logic [62-FRAC_BITS:0]                         fin_int,
   output logic [dsf_pkg::frac_width(FRAC_DIGITS)-1:0]   fin_frac
);
   import dsf_pkg::*;

   localparam int IW = 64 - FRAC_BITS;
   localparam int DW = frac_width(FRAC_DIGITS);
   localparam logic [IW-1:0] INT_CAP = {1'b1, {(IW-1){1'b0}}};
   localparam logic [2:0] FRAC_LIMIT = 3'(FRAC_DIGITS);

   dsf_phase_type  phase_ff, phase_in, phase_step;
   logic           negative_ff, negative_in, negative_step;
   logic [IW-1:0]  int_acc_ff, int_acc_in, int_acc_step;
   logic [DW-1:0]  frac_acc_ff, frac_acc_in, frac_acc_step;
   logic [2:0]     frac_count_ff, frac_count_in, frac_count_step;
   logic [5:0]     pre_dot_ff, pre_dot_in, pre_dot_step;
   logic           dot_found_ff, dot_found_in, dot_found_step;
   dsf_status_type error_ff, error_in, error_step;

   logic           fin_valid_ff, fin_valid_in;
   dsf_ctl_type    fin_ctl_ff;
   logic [IW-2:0]  fin_int_ff;
   logic [DW-1:0]  fin_frac_ff;

   logic           accept;
   logic           active, live;
   logic           is_dig, is_dot, is_sign, is_nl, is_nul;
   logic [3:0]     digit;
   logic [IW+3:0]  int_sum;
   logic [IW-1:0]  int_grow;
   logic           int_take, frac_take, count_take;
   logic           long_err, head_err, junk_err, end_head;

   assign req_ready = !fin_valid_ff || fin_ready;
   assign accept = req_valid && req_ready;

   assign is_dig = char_code inside {[CH_ZERO:CH_NINE]};
   assign is_dot = char_code == CH_DOT;
   assign is_sign = char_code inside {CH_PLUS, CH_MINUS};
   assign is_nl = char_code == CH_NEWLINE;
   assign is_nul = char_code == CH_NUL;
   assign digit = char_code[3:0];
   assign active = phase_ff != PH_ENDED;
   assign live = active && !is_nul;

   always_comb begin
      phase_step = phase_ff;
      if (active) begin
         if (is_nul) begin
            phase_step = PH_ENDED;
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (is_sign) phase_step = PH_SIGNED;
                  else if (is_dig) phase_step = PH_INT;
                  else phase_step = PH_FAILED;
               end
               PH_SIGNED: begin
                  phase_step = is_dig ? PH_INT : PH_FAILED;
               end
               PH_INT: begin
                  if (is_dig) phase_step = PH_INT;
                  else if (is_dot) phase_step = PH_FRAC;
                  else if (is_nl) phase_step = PH_DONE;
                  else phase_step = PH_FAILED;
               end
               PH_FRAC: begin
                  if (is_dig) phase_step = PH_FRAC;
                  else if (is_nl) phase_step = PH_DONE;
                  else phase_step = PH_FAILED;
               end
               default: phase_step = phase_ff;
            endcase
         end
      end
      phase_in = phase_ff;
      if (accept) begin
         phase_in = last_char ? PH_START : phase_step;
      end
   end

   always_comb begin
      int_sum = (IW+4)'({int_acc_ff, 3'b000}) + (IW+4)'({int_acc_ff, 1'b0}) + (IW+4)'(digit);
      if (int_acc_ff[IW-1]) begin
         int_grow = INT_CAP;
      end else if (int_sum > (IW+4)'(INT_CAP)) begin
         int_grow = INT_CAP;
      end else begin
         int_grow = int_sum[IW-1:0];
      end

      int_take = live && is_dig &&
         (phase_ff == PH_START || phase_ff == PH_SIGNED || phase_ff == PH_INT);
      frac_take = live && is_dig && phase_ff == PH_FRAC && frac_count_ff < FRAC_LIMIT;
      count_take = live && !dot_found_ff && !is_dot;

      pre_dot_step = pre_dot_ff;
      if (count_take && pre_dot_ff != 6'd63) begin
         pre_dot_step = pre_dot_ff + 6'd1;
      end
      long_err = count_take && pre_dot_step > max_int_chars;
      dot_found_step = dot_found_ff || (live && is_dot);

      head_err = active && ((is_nul && (phase_ff == PH_START || phase_ff == PH_SIGNED)) ||
         (!is_nul && ((phase_ff == PH_START && !is_sign && !is_dig) ||
                      (phase_ff == PH_SIGNED && !is_dig))));
      junk_err = live && ((phase_ff == PH_INT && !is_dig && !is_dot && !is_nl) ||
         (phase_ff == PH_FRAC && !is_dig && !is_nl));
      end_head = last_char && (phase_step == PH_START || phase_step == PH_SIGNED);

      error_step = error_ff;
      if (long_err) error_step = ST_LONG;
      if ((head_err || end_head) && error_step == ST_OK) error_step = ST_HEAD;
      if (junk_err && error_step == ST_OK) error_step = ST_JUNK;

      negative_step = negative_ff;
      if (live && phase_ff == PH_START && is_sign) begin
         negative_step = char_code == CH_MINUS;
      end

      int_acc_step = int_take ? int_grow : int_acc_ff;
      frac_acc_step = frac_acc_ff;
      frac_count_step = frac_count_ff;
      if (frac_take) begin
         frac_acc_step = frac_acc_ff +
            DW'({28'd0, digit} * pow10(FRAC_LIMIT - 3'd1 - frac_count_ff));
         frac_count_step = frac_count_ff + 3'd1;
      end

      negative_in = negative_ff;
      int_acc_in = int_acc_ff;
      frac_acc_in = frac_acc_ff;
      frac_count_in = frac_count_ff;
      pre_dot_in = pre_dot_ff;
      dot_found_in = dot_found_ff;
      error_in = error_ff;
      if (accept) begin
         if (last_char) begin
            negative_in = 1'b0;
            int_acc_in = '0;
            frac_acc_in = '0;
            frac_count_in = '0;
            pre_dot_in = '0;
            dot_found_in = 1'b0;
            error_in = ST_OK;
         end else begin
            negative_in = negative_step;
            int_acc_in = int_acc_step;
            frac_acc_in = frac_acc_step;
            frac_count_in = frac_count_step;
            pre_dot_in = pre_dot_step;
            dot_found_in = dot_found_step;
            error_in = error_step;
         end
      end

      fin_valid_in = fin_valid_ff && !fin_ready;
      if (accept && last_char) fin_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         negative_ff <= 1'b0;
         int_acc_ff <= '0;
         frac_acc_ff <= '0;
         frac_count_ff <= '0;
         pre_dot_ff <= '0;
         dot_found_ff <= 1'b0;
         error_ff <= ST_OK;
         fin_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         negative_ff <= negative_in;
         int_acc_ff <= int_acc_in;
         frac_acc_ff <= frac_acc_in;
         frac_count_ff <= frac_count_in;
         pre_dot_ff <= pre_dot_in;
         dot_found_ff <= dot_found_in;
         error_ff <= error_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last_char) begin
         fin_ctl_ff.negative <= negative_step;
         fin_ctl_ff.saturated <= int_acc_step[IW-1];
         fin_ctl_ff.status <= error_step;
         fin_int_ff <= int_acc_step[IW-2:0];
         fin_frac_ff <= frac_acc_step;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin_ctl = fin_ctl_ff;
   assign fin_int = fin_int_ff;
   assign fin_frac = fin_frac_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && last_char |=> phase_ff == PH_START && error_ff == ST_OK)
      else $error("parse state not cleared after last character");

   a_frac_count_bound: assert property (@(posedge clock) disable iff (reset)
      frac_count_ff <= FRAC_LIMIT)
      else $error("fraction digit count past limit");

   a_int_cap: assert property (@(posedge clock) disable iff (reset)
      int_acc_ff <= INT_CAP)
      else $error("integer accumulator above saturation cap");

endmodule

// ===== rtl/core/dsf_convert.sv =====
// Fraction scaling by reciprocal multiply with one correction step, and result assembly.
// Depends on dsf_pkg.
module dsf_convert #(
   parameter int FRAC_BITS = dsf_pkg::DSF_FRAC_BITS,
   parameter int FRAC_DIGITS = dsf_pkg::DSF_FRAC_DIGITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          fin_valid,
   output logic                                          fin_ready,
   input  dsf_pkg::dsf_ctl_type                          fin_ctl,
   input  logic [62-FRAC_BITS:0]                         fin_int,
   input  logic [dsf_pkg::frac_width(FRAC_DIGITS)-1:0]   fin_frac,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic signed [63:0]                            rsp_value,
   output logic [1:0]                                    rsp_status
);
   import dsf_pkg::*;

   localparam int F = FRAC_BITS;
   localparam int IW = 64 - FRAC_BITS;
   localparam int DW = frac_width(FRAC_DIGITS);
   localparam int RW = FRAC_BITS + 1;
   localparam logic [31:0] SCALE = pow10(3'(FRAC_DIGITS));
   localparam logic [63:0] RECIP = (64'd1 << (DW + FRAC_BITS)) / {32'd0, SCALE};
   localparam logic [DW-1:0] DIVISOR = SCALE[DW-1:0];
   localparam logic [63:0] POS_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] NEG_MIN = {1'b1, {63{1'b0}}};

   logic              s1_valid_ff, s1_valid_in;
   dsf_ctl_type       s1_ctl_ff;
   logic [IW-2:0]     s1_int_ff;
   logic [DW-1:0]     s1_frac_ff;
   logic [DW+RW-1:0]  s1_prod_ff;

   logic              s2_valid_ff, s2_valid_in;
   dsf_ctl_type       s2_ctl_ff;
   logic [IW-2:0]     s2_int_ff;
   logic [DW-1:0]     s2_frac_ff;
   logic [F-1:0]      s2_qest_ff;
   logic [DW+F-1:0]   s2_qc_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_value_ff, rsp_value_in;
   dsf_status_type    rsp_status_ff;

   logic              out_ready, s2_ready, s1_ready;
   logic [F-1:0]      s1_qest;
   logic [DW+F-1:0]   rem;
   logic              fix;
   logic [F-1:0]      quot;
   logic [63:0]       mag;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign fin_ready = s1_ready;

   assign s1_qest = s1_prod_ff[DW +: F];

   always_comb begin
      rem = {s2_frac_ff, {F{1'b0}}} - s2_qc_ff;
      fix = rem >= (DW+F)'(DIVISOR);
      quot = s2_qest_ff + F'(fix);
      mag = {1'b0, s2_int_ff, quot};
      if (s2_ctl_ff.status != ST_OK) begin
         rsp_value_in = '0;
      end else if (s2_ctl_ff.saturated) begin
         rsp_value_in = s2_ctl_ff.negative ? NEG_MIN : POS_MAX;
      end else begin
         rsp_value_in = s2_ctl_ff.negative ? 64'd0 - mag : mag;
      end
      s1_valid_in = fin_valid || (s1_valid_ff && !s2_ready);
      s2_valid_in = s1_valid_ff || (s2_valid_ff && !out_ready);
      rsp_valid_in = s2_valid_ff || (rsp_valid_ff && !rsp_ready);
      if (!s1_ready) s1_valid_in = s1_valid_ff;
      if (!s2_ready) s2_valid_in = s2_valid_ff;
      if (!out_ready) rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ctl_ff <= fin_ctl;
         s1_int_ff <= fin_int;
         s1_frac_ff <= fin_frac;
         s1_prod_ff <= fin_frac * RECIP[RW-1:0];
      end
      if (s2_ready) begin
         s2_ctl_ff <= s1_ctl_ff;
         s2_int_ff <= s1_int_ff;
         s2_frac_ff <= s1_frac_ff;
         s2_qest_ff <= s1_qest;
         s2_qc_ff <= s1_qest * DIVISOR;
      end
      if (out_ready) begin
         rsp_value_ff <= rsp_value_in;
         rsp_status_ff <= s2_ctl_ff.status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   a_one_correction: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> rem < {1'b0, DIVISOR, {F{1'b0}}} >> (F - 1))
      else $error("reciprocal estimate off by more than one");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == 64'd0)
      else $error("nonzero value with error status");

endmodule
